>>> rtl/dfbp_pkg.sv
// Shared types and constants for the dual byte queue port.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dfbp_pkg;

    localparam int RING_DEPTH_DEF = 1024;

    localparam logic [2:0] ACT_STATUS    = 3'd0;
    localparam logic [2:0] ACT_CPU_READ  = 3'd1;
    localparam logic [2:0] ACT_CPU_WRITE = 3'd2;
    localparam logic [2:0] ACT_NET_PUSH  = 3'd3;
    localparam logic [2:0] ACT_NET_POP   = 3'd4;

    localparam logic [7:0] STATUS_READY = 8'h02;
    localparam logic [7:0] STATUS_IDLE  = 8'h00;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_value;
        logic       accepted;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic take;
        logic load;
    } t_dp_cmd;

endpackage

`default_nettype wire

>>> rtl/dfbp_ctrl.sv
// Sequencer for the byte queue port: handshakes and datapath commands.
// Depends on dfbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dfbp_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire              i_out_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output dfbp_pkg::t_dp_cmd o_cmd
);

    dfbp_pkg::t_state r_state;
    dfbp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dfbp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dfbp_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = dfbp_pkg::ST_LOAD;
                end
            end
            dfbp_pkg::ST_LOAD: begin
                n_state = dfbp_pkg::ST_RESP;
            end
            dfbp_pkg::ST_RESP: begin
                if (i_out_ready) begin
                    n_state = i_in_valid ? dfbp_pkg::ST_LOAD : dfbp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dfbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd.load  = 1'b0;
        case (r_state)
            dfbp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            dfbp_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
            end
            dfbp_pkg::ST_RESP: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        o_cmd.take = o_in_ready & i_in_valid;
    end

endmodule

`default_nettype wire

>>> rtl/dfbp_datapath.sv
// Queue pointers, the two byte stores and the result register.
// Depends on dfbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dfbp_datapath #(
    parameter int RING_DEPTH = dfbp_pkg::RING_DEPTH_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  dfbp_pkg::t_dp_cmd   i_cmd,
    input  dfbp_pkg::t_in_item  i_item,
    output dfbp_pkg::t_out_item o_item
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam logic [PW-1:0] LAST = PW'(RING_DEPTH - 1);

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] pos);
        advance = (pos == LAST) ? '0 : pos + 1'b1;
    endfunction

    logic [7:0] r_rx_mem [RING_DEPTH];
    logic [7:0] r_tx_mem [RING_DEPTH];
    logic [7:0] r_rx_rdata;
    logic [7:0] r_tx_rdata;

    logic [PW-1:0] r_rx_wr;
    logic [PW-1:0] r_rx_rd;
    logic [PW-1:0] r_tx_wr;
    logic [PW-1:0] r_tx_rd;

    logic       r_ok;
    logic       r_pop;
    logic       r_pop_tx;
    logic [7:0] r_imm;
    dfbp_pkg::t_out_item r_out;

    logic       rx_empty, rx_full, tx_empty, tx_full;
    logic       rx_we, rx_re, tx_we, tx_re;
    logic       n_ok;
    logic [7:0] n_imm;

    assign rx_empty = (r_rx_wr == r_rx_rd);
    assign tx_empty = (r_tx_wr == r_tx_rd);
    assign rx_full  = (advance(r_rx_wr) == r_rx_rd);
    assign tx_full  = (advance(r_tx_wr) == r_tx_rd);

    always_comb begin
        rx_we = 1'b0;
        rx_re = 1'b0;
        tx_we = 1'b0;
        tx_re = 1'b0;
        n_ok  = 1'b0;
        n_imm = 8'h00;
        case (i_item.action)
            dfbp_pkg::ACT_STATUS: begin
                n_imm = rx_empty ? dfbp_pkg::STATUS_IDLE : dfbp_pkg::STATUS_READY;
            end
            dfbp_pkg::ACT_CPU_READ: begin
                n_ok  = !rx_empty;
                rx_re = i_cmd.take & !rx_empty;
            end
            dfbp_pkg::ACT_CPU_WRITE: begin
                n_ok  = !tx_full;
                tx_we = i_cmd.take & !tx_full;
            end
            dfbp_pkg::ACT_NET_PUSH: begin
                n_ok  = !rx_full;
                rx_we = i_cmd.take & !rx_full;
            end
            dfbp_pkg::ACT_NET_POP: begin
                n_ok  = !tx_empty;
                tx_re = i_cmd.take & !tx_empty;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wr <= '0;
            r_rx_rd <= '0;
            r_tx_wr <= '0;
            r_tx_rd <= '0;
        end else begin
            if (rx_we) r_rx_wr <= advance(r_rx_wr);
            if (rx_re) r_rx_rd <= advance(r_rx_rd);
            if (tx_we) r_tx_wr <= advance(r_tx_wr);
            if (tx_re) r_tx_rd <= advance(r_tx_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_we) r_rx_mem[r_rx_wr] <= i_item.data_byte;
        if (rx_re) r_rx_rdata <= r_rx_mem[r_rx_rd];
    end

    always_ff @(posedge i_clk) begin
        if (tx_we) r_tx_mem[r_tx_wr] <= i_item.data_byte;
        if (tx_re) r_tx_rdata <= r_tx_mem[r_tx_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_ok     <= n_ok;
            r_pop    <= rx_re | tx_re;
            r_pop_tx <= tx_re;
            r_imm    <= n_imm;
        end
        if (i_cmd.load) begin
            r_out.accepted   <= r_ok;
            r_out.read_value <= r_pop ? (r_pop_tx ? r_tx_rdata : r_rx_rdata) : r_imm;
        end
    end

    assign o_item = r_out;

endmodule

`default_nettype wire

>>> rtl/dual_fifo_byte_port.sv
// Dual byte queue port: receive queue (network to cpu), transmit queue (cpu to network).
// An accepted input moves the sequencer to the load state; the result is valid in the
// respond state after it. One transaction is in flight at a time: the registered store
// read precedes the result register load; a new input is taken as the result leaves.
// Reset: synchronous, active low; clears queue positions and the sequencer, stores
// are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module dual_fifo_byte_port #(
    parameter int RING_DEPTH = dfbp_pkg::RING_DEPTH_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  dfbp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output dfbp_pkg::t_out_item o_out_item
);

    dfbp_pkg::t_dp_cmd cmd;

    dfbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    dfbp_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_in_item),
        .o_item  (o_out_item)
    );

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> ##1 o_out_valid)
        else $error("result not presented two cycles after input transaction");

    a_load_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (!o_in_ready && !o_out_valid))
        else $error("input taken or result shown during load cycle");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while result stalled");

endmodule

`default_nettype wire

>>> test/tb_dual_fifo_byte_port.sv
// Testbench for dual_fifo_byte_port: random and directed cpu/network accesses
// with a transaction-level predictor of both byte queues. Depends on rtl/dfbp_pkg.sv
// and rtl/dual_fifo_byte_port.sv.
`timescale 1ns / 1ps

module tb_dual_fifo_byte_port;

    localparam int DEPTH       = dfbp_pkg::RING_DEPTH_DEF;
    localparam int TAIL_ITEMS  = 150;
    localparam int CYCLE_LIMIT = 600000;
    localparam int FULL_TRIES  = 8;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    dfbp_pkg::t_in_item  in_item = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    dfbp_pkg::t_out_item out_item;

    dfbp_pkg::t_in_item  accesses_to_send[$];
    dfbp_pkg::t_out_item results_due[$];

    // predictor state
    logic [7:0]  rx_mem [DEPTH];
    logic [7:0]  tx_mem [DEPTH];
    int unsigned rx_wr = 0, rx_rd = 0, tx_wr = 0, tx_rd = 0;

    // generator bookkeeping
    int rx_fill = 0, tx_fill = 0, rx_refusals = 0, tx_refusals = 0;
    int total_accesses = 0;
    int accesses_taken = 0;
    int mismatches = 0;
    int cycles = 0;
    int idle_pct = 0;
    int in_gap = 0;
    int out_gap = 0;

    dual_fifo_byte_port #(
        .RING_DEPTH (DEPTH)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned next_pos(int unsigned p);
        return (p == DEPTH - 1) ? 0 : p + 1;
    endfunction

    function automatic dfbp_pkg::t_out_item port_access(dfbp_pkg::t_in_item acc);
        dfbp_pkg::t_out_item r;
        r = '0;
        case (acc.action)
            dfbp_pkg::ACT_STATUS: begin
                r.read_value = (rx_wr == rx_rd) ? dfbp_pkg::STATUS_IDLE
                                                : dfbp_pkg::STATUS_READY;
            end
            dfbp_pkg::ACT_CPU_READ: begin
                if (rx_wr != rx_rd) begin
                    r.read_value = rx_mem[rx_rd];
                    r.accepted   = 1'b1;
                    rx_rd        = next_pos(rx_rd);
                end
            end
            dfbp_pkg::ACT_CPU_WRITE: begin
                if (next_pos(tx_wr) != tx_rd) begin
                    tx_mem[tx_wr] = acc.data_byte;
                    tx_wr         = next_pos(tx_wr);
                    r.accepted    = 1'b1;
                end
            end
            dfbp_pkg::ACT_NET_PUSH: begin
                if (next_pos(rx_wr) != rx_rd) begin
                    rx_mem[rx_wr] = acc.data_byte;
                    rx_wr         = next_pos(rx_wr);
                    r.accepted    = 1'b1;
                end
            end
            dfbp_pkg::ACT_NET_POP: begin
                if (tx_wr != tx_rd) begin
                    r.read_value = tx_mem[tx_rd];
                    r.accepted   = 1'b1;
                    tx_rd        = next_pos(tx_rd);
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic add_access(logic [2:0] act, logic [7:0] data);
        dfbp_pkg::t_in_item acc;
        acc.action    = act;
        acc.data_byte = data;
        accesses_to_send.push_back(acc);
        case (act)
            dfbp_pkg::ACT_CPU_READ: begin
                if (rx_fill != 0) rx_fill--;
            end
            dfbp_pkg::ACT_CPU_WRITE: begin
                if (tx_fill < DEPTH - 1) tx_fill++;
                else tx_refusals++;
            end
            dfbp_pkg::ACT_NET_PUSH: begin
                if (rx_fill < DEPTH - 1) rx_fill++;
                else rx_refusals++;
            end
            dfbp_pkg::ACT_NET_POP: begin
                if (tx_fill != 0) tx_fill--;
            end
            default: begin
            end
        endcase
    endtask

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_ready) begin
                if (in_gap != 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (accesses_to_send.size() > TAIL_ITEMS &&
                             $urandom_range(0, 99) < idle_pct) begin
                    in_gap = $urandom_range(0, 15);
                    in_valid <= 1'b0;
                end else if (accesses_to_send.size() != 0) begin
                    in_item  <= accesses_to_send.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: predict on input transaction, then check output transaction
    always @(posedge clk) begin
        dfbp_pkg::t_out_item exp_res;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                results_due.push_back(port_access(in_item));
                accesses_taken++;
            end
            if (out_valid && out_ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0h/%0b",
                                              out_item.read_value, out_item.accepted));
                end else begin
                    exp_res = results_due.pop_front();
                    if (out_item.read_value !== exp_res.read_value)
                        report_mismatch($sformatf("read_value %0h, expected %0h",
                                                  out_item.read_value, exp_res.read_value));
                    if (out_item.accepted !== exp_res.accepted)
                        report_mismatch($sformatf("accepted %0b, expected %0b",
                                                  out_item.accepted, exp_res.accepted));
                end
            end
            if (out_gap != 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end else if (accesses_to_send.size() > TAIL_ITEMS &&
                         $urandom_range(0, 99) < idle_pct) begin
                out_gap = $urandom_range(0, 15);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // idle density changes over the run, including stretches with none
    always @(posedge clk) begin
        cycles++;
        if (cycles % 128 == 0) idle_pct <= 15 * $urandom_range(0, 2);
        if (cycles > CYCLE_LIMIT) begin
            $display("** dual_fifo_byte_port: FAILED **");
            $finish;
        end
    end

    initial begin
        // empty queues
        add_access(dfbp_pkg::ACT_STATUS, 8'($urandom));
        add_access(dfbp_pkg::ACT_CPU_READ, 8'($urandom));
        add_access(dfbp_pkg::ACT_NET_POP, 8'($urandom));
        // receive path with extreme bytes
        add_access(dfbp_pkg::ACT_NET_PUSH, 8'h00);
        add_access(dfbp_pkg::ACT_NET_PUSH, 8'hFF);
        add_access(dfbp_pkg::ACT_NET_PUSH, 8'hA5);
        add_access(dfbp_pkg::ACT_STATUS, 8'($urandom));
        repeat (3) add_access(dfbp_pkg::ACT_CPU_READ, 8'($urandom));
        add_access(dfbp_pkg::ACT_CPU_READ, 8'($urandom));
        add_access(dfbp_pkg::ACT_STATUS, 8'($urandom));
        // transmit path
        add_access(dfbp_pkg::ACT_CPU_WRITE, 8'hFF);
        add_access(dfbp_pkg::ACT_CPU_WRITE, 8'h5A);
        add_access(dfbp_pkg::ACT_CPU_WRITE, 8'h00);
        repeat (4) add_access(dfbp_pkg::ACT_NET_POP, 8'($urandom));
        // unused action codes
        for (int a = int'(dfbp_pkg::ACT_NET_POP) + 1;
             a < 2 ** $bits(dfbp_pkg::ACT_STATUS); a++)
            add_access(3'(a), 8'hFF);

        // fill the receive queue until pushes get refused
        rx_refusals = 0;
        while (rx_refusals < FULL_TRIES) begin
            if ($urandom_range(0, 99) < 95) begin
                add_access(dfbp_pkg::ACT_NET_PUSH, 8'($urandom));
            end else begin
                add_access(3'($urandom_range(dfbp_pkg::ACT_STATUS, dfbp_pkg::ACT_NET_POP)),
                           8'($urandom));
            end
        end
        // fill the transmit queue while the receive side drains a little
        tx_refusals = 0;
        while (tx_refusals < FULL_TRIES) begin
            if ($urandom_range(0, 99) < 95) begin
                add_access(dfbp_pkg::ACT_CPU_WRITE, 8'($urandom));
            end else begin
                add_access(3'($urandom_range(dfbp_pkg::ACT_STATUS, dfbp_pkg::ACT_NET_POP)),
                           8'($urandom));
            end
        end
        repeat (250)
            add_access(3'($urandom_range(dfbp_pkg::ACT_STATUS, dfbp_pkg::ACT_NET_POP)),
                       8'($urandom));
        total_accesses = accesses_to_send.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (accesses_taken != total_accesses || results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0) begin
            $display("** dual_fifo_byte_port: PASSED **");
        end else begin
            $display("** dual_fifo_byte_port: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/dfbp_pkg.sv
rtl/dfbp_ctrl.sv
rtl/dfbp_datapath.sv
rtl/dual_fifo_byte_port.sv
test/tb_dual_fifo_byte_port.sv
